FILE: sv/bpl_pkg.sv
// ----------------------------------------------------------------------------
// bpl_pkg: shared types and constants for the beat phase PI lock
// Widths, register indexes, reset values and the config/item/result types.
// ----------------------------------------------------------------------------
package bpl_pkg;

  localparam int PHASE_BITS = 16;

  localparam int ERR_W   = PHASE_BITS + 1;   // wrapped error, signed
  localparam int MAG_W   = PHASE_BITS;       // |error|
  localparam int DT_W    = 12;
  localparam int GAIN_W  = 10;
  localparam int LIM_W   = 15;
  localparam int WIN_W   = 16;
  localparam int NUDGE_W = LIM_W + 1;

  // serial multiplier geometry
  localparam int MC_W   = GAIN_W + DT_W;
  localparam int MP_W   = (MAG_W > DT_W) ? MAG_W : DT_W;
  localparam int PROD_W = MC_W + MP_W;
  localparam int CNT_W  = $clog2(MP_W);

  // fixed point of the integral and the sum
  localparam int FRAC_SH    = PHASE_BITS + 10;
  localparam int KP_SH      = 16;
  localparam int INT_W      = LIM_W + FRAC_SH + 1;
  localparam int SUM_W      = INT_W + 2;
  localparam int Q_W        = SUM_W + 1 - FRAC_SH;
  localparam int ROUND_BIAS = 1 << (FRAC_SH - 1);

  localparam int HALF = 1 << (PHASE_BITS - 1);
  localparam int FULL = 1 << PHASE_BITS;
  localparam logic signed [ERR_W:0] HALF_S = (ERR_W + 1)'(HALF);
  localparam logic signed [ERR_W:0] FULL_S = (ERR_W + 1)'(FULL);

  localparam int DT_MIN = 66;
  localparam int DT_MAX = 3277;

  // APB register map
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_KP_NORMAL     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KP_BOOST      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KI_GAIN       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_NORMAL  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_BOOST   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LOCK_WINDOW   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CHANGE_WINDOW = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_DT_DEFAULT    = 3'd7;

  localparam logic [GAIN_W-1:0] RST_KP_NORMAL     = 10'd224;
  localparam logic [GAIN_W-1:0] RST_KP_BOOST      = 10'd480;
  localparam logic [GAIN_W-1:0] RST_KI_GAIN       = 10'd144;
  localparam logic [LIM_W-1:0]  RST_LIMIT_NORMAL  = 15'd6144;
  localparam logic [LIM_W-1:0]  RST_LIMIT_BOOST   = 15'd15360;
  localparam logic [WIN_W-1:0]  RST_LOCK_WINDOW   = 16'd655;
  localparam logic [GAIN_W-1:0] RST_CHANGE_WINDOW = 10'd1;
  localparam logic [DT_W-1:0]   RST_DT_DEFAULT    = 12'd262;

  // stream payload widths
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic [GAIN_W-1:0] kp_normal;
    logic [GAIN_W-1:0] kp_boost;
    logic [GAIN_W-1:0] ki_gain;
    logic [LIM_W-1:0]  limit_normal;
    logic [LIM_W-1:0]  limit_boost;
    logic [WIN_W-1:0]  lock_window;
    logic [GAIN_W-1:0] change_window;
    logic [DT_W-1:0]   dt_default;
  } cfg_t;

  typedef struct packed {
    logic        follower_active;
    logic        master_ready;
    logic [15:0] master_phase;
    logic [15:0] own_phase;
    logic [15:0] elapsed_ticks;
    logic        resync;
  } item_t;

  typedef struct packed {
    logic signed [NUDGE_W-1:0] nudge;
    logic                      nudge_updated;
    logic                      boost_active;
    logic signed [ERR_W-1:0]   phase_error;
  } res_t;

endpackage

FILE: sv/bpl_regs.sv
// ----------------------------------------------------------------------------
// bpl_regs: APB configuration registers
// Eight word registers holding gains, ceilings, windows and default dt.
// ----------------------------------------------------------------------------
module bpl_regs import bpl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_normal     <= RST_KP_NORMAL;
      cfg_r.kp_boost      <= RST_KP_BOOST;
      cfg_r.ki_gain       <= RST_KI_GAIN;
      cfg_r.limit_normal  <= RST_LIMIT_NORMAL;
      cfg_r.limit_boost   <= RST_LIMIT_BOOST;
      cfg_r.lock_window   <= RST_LOCK_WINDOW;
      cfg_r.change_window <= RST_CHANGE_WINDOW;
      cfg_r.dt_default    <= RST_DT_DEFAULT;
    end else if (wr_en) begin
      case (idx)
        REG_KP_NORMAL:     cfg_r.kp_normal     <= pwdata[GAIN_W-1:0];
        REG_KP_BOOST:      cfg_r.kp_boost      <= pwdata[GAIN_W-1:0];
        REG_KI_GAIN:       cfg_r.ki_gain       <= pwdata[GAIN_W-1:0];
        REG_LIMIT_NORMAL:  cfg_r.limit_normal  <= pwdata[LIM_W-1:0];
        REG_LIMIT_BOOST:   cfg_r.limit_boost   <= pwdata[LIM_W-1:0];
        REG_LOCK_WINDOW:   cfg_r.lock_window   <= pwdata[WIN_W-1:0];
        REG_CHANGE_WINDOW: cfg_r.change_window <= pwdata[GAIN_W-1:0];
        REG_DT_DEFAULT:    cfg_r.dt_default    <= pwdata[DT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KP_NORMAL:     prdata = DATA_W'(cfg_r.kp_normal);
      REG_KP_BOOST:      prdata = DATA_W'(cfg_r.kp_boost);
      REG_KI_GAIN:       prdata = DATA_W'(cfg_r.ki_gain);
      REG_LIMIT_NORMAL:  prdata = DATA_W'(cfg_r.limit_normal);
      REG_LIMIT_BOOST:   prdata = DATA_W'(cfg_r.limit_boost);
      REG_LOCK_WINDOW:   prdata = DATA_W'(cfg_r.lock_window);
      REG_CHANGE_WINDOW: prdata = DATA_W'(cfg_r.change_window);
      REG_DT_DEFAULT:    prdata = DATA_W'(cfg_r.dt_default);
      default:           prdata = '0;
    endcase
  end

endmodule

FILE: sv/bpl_smul.sv
// ----------------------------------------------------------------------------
// bpl_smul: bit-serial shift-add multiplier
// Unsigned, one multiplier bit per cycle, MP_W multiplier bits per product.
// ----------------------------------------------------------------------------
module bpl_smul import bpl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MC_W-1:0]   mcand,
  input  logic [MP_W-1:0]   mplier,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic [MC_W-1:0]  mc_r;
  logic [PROD_W:0]  acc_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [MC_W-1:0]  addend;
  logic [MC_W+1:0]  hi_sum;

  // high half gets the multiplicand when the current low bit is set,
  // then the whole word shifts right by one
  assign addend = acc_r[0] ? mc_r : '0;
  assign hi_sum = {1'b0, acc_r[PROD_W:MP_W]} + (MC_W + 2)'(addend);

  assign done = done_r;
  assign prod = acc_r[PROD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(MP_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_r  <= mcand;
      acc_r <= (PROD_W + 1)'(mplier);
    end else if (busy_r) begin
      acc_r <= {hi_sum, acc_r[MP_W-1:1]};
    end
  end

endmodule

FILE: sv/bpl_core.sv
// ----------------------------------------------------------------------------
// bpl_core: PI phase lock sequencer and datapath
// Wraps the phase error, runs the three products through the serial
// multiplier, integrates with clamping, rounds and applies the nudge.
// ----------------------------------------------------------------------------
module bpl_core import bpl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  typedef enum logic [2:0] {
    S_IDLE, S_KD, S_IE, S_INTEG, S_KE, S_SUM, S_ROUND, S_FINAL
  } state_t;

  state_t state_r, state_nxt;

  // controller state
  logic                      boost_r, boost_nxt;
  logic                      clk_valid_r, clk_valid_nxt;
  logic                      active_r, active_nxt;
  logic signed [NUDGE_W-1:0] nudge_r, nudge_nxt;
  logic signed [INT_W-1:0]   integ_r, integ_nxt;

  // per-transaction working registers
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic [MAG_W-1:0]          emag_r, emag_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic [Q_W-1:0]            q_r, q_nxt;
  logic                      qneg_r, qneg_nxt;

  // multiplier hookup
  logic              mul_start;
  logic [MC_W-1:0]   mul_mcand;
  logic [MP_W-1:0]   mul_mplier;
  logic              mul_done;
  logic [PROD_W-1:0] mul_prod;

  // combinational helpers
  logic                      accept;
  logic                      active_in;
  logic signed [ERR_W:0]     diff, wrapped;
  logic signed [ERR_W-1:0]   err_in, err_neg;
  logic [MAG_W-1:0]          emag_in;
  logic [DT_W-1:0]           dt_in;
  logic [GAIN_W-1:0]         kp_sel;
  logic [LIM_W-1:0]          lim_sel;
  logic signed [INT_W:0]     lim_s, prod_ext, inc, isum, iclamp;
  logic signed [SUM_W-1:0]   pmag, pterm, integ_ext;
  logic [SUM_W-1:0]          smag;
  logic [SUM_W:0]            rnd;
  logic [LIM_W-1:0]          nmag;
  logic signed [NUDGE_W-1:0] nn_pos, nn;
  logic signed [NUDGE_W:0]   delta, dmag;
  logic                      change, lock;

  bpl_smul u_smul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  assign item_ready = (state_r == S_IDLE);
  assign accept     = item_ready & item_valid;
  assign active_in  = item.follower_active & item.master_ready;

  // error wrap to plus or minus half a beat
  always_comb begin
    diff = $signed({2'b00, item.master_phase[PHASE_BITS-1:0]})
         - $signed({2'b00, item.own_phase[PHASE_BITS-1:0]});
    if (diff > HALF_S) begin
      wrapped = diff - FULL_S;
    end else if (diff < -HALF_S) begin
      wrapped = diff + FULL_S;
    end else begin
      wrapped = diff;
    end
    err_in  = wrapped[ERR_W-1:0];
    err_neg = -err_in;
    emag_in = err_in[ERR_W-1] ? err_neg[MAG_W-1:0] : err_in[MAG_W-1:0];
  end

  // elapsed time, clamped only while the clock is running
  always_comb begin
    if (clk_valid_r && !item.resync) begin
      if (item.elapsed_ticks < 16'(DT_MIN)) begin
        dt_in = DT_W'(DT_MIN);
      end else if (item.elapsed_ticks > 16'(DT_MAX)) begin
        dt_in = DT_W'(DT_MAX);
      end else begin
        dt_in = item.elapsed_ticks[DT_W-1:0];
      end
    end else begin
      dt_in = cfg.dt_default;
    end
  end

  assign kp_sel  = boost_r ? cfg.kp_boost : cfg.kp_normal;
  assign lim_sel = boost_r ? cfg.limit_boost : cfg.limit_normal;
  assign lim_s   = {2'b00, lim_sel, {FRAC_SH{1'b0}}};

  // integral update with anti-windup clamp
  always_comb begin
    prod_ext = (INT_W + 1)'(mul_prod);
    inc      = err_r[ERR_W-1] ? -prod_ext : prod_ext;
    isum     = $signed({integ_r[INT_W-1], integ_r}) + inc;
    if (isum > lim_s) begin
      iclamp = lim_s;
    end else if (isum < -lim_s) begin
      iclamp = -lim_s;
    end else begin
      iclamp = isum;
    end
  end

  // proportional term scaled up to the integral's fixed point
  always_comb begin
    pmag      = {1'b0, mul_prod[SUM_W-KP_SH-2:0], {KP_SH{1'b0}}};
    pterm     = err_r[ERR_W-1] ? -pmag : pmag;
    integ_ext = {{(SUM_W - INT_W){integ_r[INT_W-1]}}, integ_r};
  end

  // round half away from zero on the magnitude
  always_comb begin
    smag = sum_r[SUM_W-1] ? -sum_r : sum_r;
    rnd  = {1'b0, smag} + (SUM_W + 1)'(ROUND_BIAS);
  end

  // final clamp, change window and lock window
  always_comb begin
    nmag   = (q_r > Q_W'(lim_sel)) ? lim_sel : q_r[LIM_W-1:0];
    nn_pos = {1'b0, nmag};
    nn     = qneg_r ? -nn_pos : nn_pos;
    delta  = {nn[NUDGE_W-1], nn} - {nudge_r[NUDGE_W-1], nudge_r};
    dmag   = delta[NUDGE_W] ? -delta : delta;
    change = dmag > (NUDGE_W + 1)'(cfg.change_window);
    lock   = emag_r < cfg.lock_window;
  end

  always_comb begin
    if (active_r) begin
      res.nudge         = change ? nn : nudge_r;
      res.nudge_updated = change;
      res.boost_active  = boost_r & ~lock;
    end else begin
      res.nudge         = '0;
      res.nudge_updated = (nudge_r != '0);
      res.boost_active  = boost_r;
    end
    res.phase_error = err_r;
  end

  assign res_valid = (state_r == S_FINAL);

  // multiplier operand selection
  always_comb begin
    mul_start  = 1'b0;
    mul_mcand  = MC_W'(cfg.ki_gain);
    mul_mplier = MP_W'(dt_in);
    case (state_r)
      S_IDLE: begin
        mul_start = accept & active_in;
      end
      S_KD: begin
        mul_start  = mul_done;
        mul_mcand  = mul_prod[MC_W-1:0];
        mul_mplier = MP_W'(emag_r);
      end
      S_INTEG: begin
        mul_start  = 1'b1;
        mul_mcand  = MC_W'(kp_sel);
        mul_mplier = MP_W'(emag_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    boost_nxt     = boost_r;
    clk_valid_nxt = clk_valid_r;
    active_nxt    = active_r;
    nudge_nxt     = nudge_r;
    integ_nxt     = integ_r;
    err_nxt       = err_r;
    emag_nxt      = emag_r;
    sum_nxt       = sum_r;
    q_nxt         = q_r;
    qneg_nxt      = qneg_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // resync wipes the loop before the step itself
          if (item.resync) begin
            boost_nxt = 1'b1;
            nudge_nxt = '0;
          end
          if (item.resync || !active_in) begin
            integ_nxt = '0;
          end
          clk_valid_nxt = active_in;
          active_nxt    = active_in;
          err_nxt       = active_in ? err_in : '0;
          emag_nxt      = emag_in;
          state_nxt     = active_in ? S_KD : S_FINAL;
        end
      end
      S_KD: begin
        if (mul_done) state_nxt = S_IE;
      end
      S_IE: begin
        if (mul_done) state_nxt = S_INTEG;
      end
      S_INTEG: begin
        integ_nxt = iclamp[INT_W-1:0];
        state_nxt = S_KE;
      end
      S_KE: begin
        if (mul_done) state_nxt = S_SUM;
      end
      S_SUM: begin
        sum_nxt   = pterm + integ_ext;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        q_nxt     = rnd[SUM_W:FRAC_SH];
        qneg_nxt  = sum_r[SUM_W-1];
        state_nxt = S_FINAL;
      end
      S_FINAL: begin
        if (res_ready) begin
          nudge_nxt = res.nudge;
          boost_nxt = res.boost_active;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      boost_r     <= 1'b0;
      clk_valid_r <= 1'b0;
      active_r    <= 1'b0;
      nudge_r     <= '0;
      integ_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      boost_r     <= boost_nxt;
      clk_valid_r <= clk_valid_nxt;
      active_r    <= active_nxt;
      nudge_r     <= nudge_nxt;
      integ_r     <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r  <= err_nxt;
    emag_r <= emag_nxt;
    sum_r  <= sum_nxt;
    q_r    <= q_nxt;
    qneg_r <= qneg_nxt;
  end

endmodule

FILE: sv/beat_phase_pi_lock.sv
// ----------------------------------------------------------------------------
// beat_phase_pi_lock: phase-locking PI loop for a sync follower deck
// Input stream of phase ticks, output stream of tempo nudges, APB config.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   one transaction per tick: gating flags, master and own phase,
//          elapsed time and a resync request. One result comes back per tick.
//   out_*  nudge in 1/1024 percent, update flag, boost flag, wrapped error.
//   cfg_*  APB registers; user writes only while no tick is in flight (unchecked).
// Sequence: an active tick makes three passes through the bit-serial multiplier
//   (ki*dt, that times |error|, kp*|error|) plus the integrate, sum, round and
//   apply steps from acceptance to out_tvalid. An inactive tick skips the
//   multiplier and goes straight to its result.
// Flow: one tick in flight; in_tready rises once the result moves into the output
//   register, so the next tick is taken while that result waits on out_tready.
// Reset: registers return to their defaults, integral and nudge clear, boost
//   off, clock invalid. A stalled receiver holds the result in the output
//   register; a second result waits in the core until the register frees up.
// ----------------------------------------------------------------------------
module beat_phase_pi_lock import bpl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [0] follower_active, [1] master_ready, [17:2] master_phase,
  // [33:18] own_phase, [49:34] elapsed_ticks, [50] resync
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] nudge, [16] nudge_updated, [17] boost_active, [34:18] phase_error
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [ADDR_W-1:0]      cfg_paddr,
  input  logic [DATA_W-1:0]      cfg_pwdata,
  output logic [DATA_W-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t  cfg;
  item_t item;
  res_t  res;
  logic  res_valid;
  logic  res_ready;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  assign item.follower_active = in_tdata[0];
  assign item.master_ready    = in_tdata[1];
  assign item.master_phase    = in_tdata[17:2];
  assign item.own_phase       = in_tdata[33:18];
  assign item.elapsed_ticks   = in_tdata[49:34];
  assign item.resync          = in_tdata[50];

  bpl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  bpl_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register frees the core as soon as it can take the result
  assign res_ready = ~out_valid_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= {5'b0, res.phase_error, res.boost_active,
                     res.nudge_updated, res.nudge};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("core took a second tick while one was in flight");

  a_idle_after_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> in_tready)
    else $error("core not idle after handing off its result");

  a_no_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !res_valid)
    else $error("result offered while the core is idle");

  a_nudge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:0] != 16'h8000))
    else $error("nudge outside the clamp range");
`endif

endmodule
